// ===== rtl/core/double_ended_record_queue_unit_defines.svh =====
// Assertion macros shared by the record queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DOUBLE_ENDED_RECORD_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_RECORD_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check prop on every rising clock edge outside reset
`define DERQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop on every rising clock edge, reset included
`define DERQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DERQ_ASSERT(lbl, clk, rst, prop, msg)
`define DERQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/derq_pkg.sv =====
// Types and codes of the record queue: operation kinds, result status codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package derq_pkg;

   // full field widths of a record at the ports
   localparam int NAME_FULL_W = 160;
   localparam int TEL_FULL_W  = 128;

   // operation kinds
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_CLEAR      = 3'd4;
   localparam logic [2:0] KIND_DUMP       = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_RECORD = 2'd0;
   localparam logic [1:0] STAT_DONE   = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_EMPTY  = 2'd3;

   typedef struct packed {
      logic op_go;       // execute a single-result operation
      logic dump_start;  // begin a dump of a non-empty list
      logic dump_step;   // send one dumped record
   } derq_cmd_type;

   typedef struct packed {
      logic is_empty;
      logic out_free;    // result register can load this cycle
      logic dump_last;   // the record about to be sent ends the dump
   } derq_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_record_queue_unit.sv =====
// Double-ended record queue: ring of DEPTH records in one RAM, pushed and
// popped at both ends, or dumped front to back. A push, pop or clear gives
// one result beat; a new operation is taken whenever the result register is
// empty or being drained that same cycle, so back-to-back single-result
// operations run one per cycle when the consumer keeps up. A dump first
// reads the front record from the RAM's single registered read port, then
// sends one record beat per cycle while the result register is free; no
// operation is taken until the last record beat is loaded. Results: status
// 1 done, 2 push refused (ring full), 3 list empty (pop or dump of an empty
// list), 0 a dumped record with last on the final one. Kinds six and seven
// are dropped with no result. Name and phone bytes beyond NAME_BYTES and
// TEL_BYTES are not stored and read back as zero. No clearing pass after
// reset: slots are only read after being written.
// Depends on derq_pkg, derq_ctrl, derq_dpath and derq_ram.
`default_nettype none

module double_ended_record_queue_unit #(
   parameter int DEPTH      = 32,
   parameter int NAME_BYTES = 20,
   parameter int TEL_BYTES  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // operation channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [63:0] req_name_part0,
   input  wire logic [63:0] req_name_part1,
   input  wire logic [31:0] req_name_part2,
   input  wire logic [63:0] req_tel_part0,
   input  wire logic [63:0] req_tel_part1,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_out_name0,
   output logic [63:0]      rsp_out_name1,
   output logic [31:0]      rsp_out_name2,
   output logic [63:0]      rsp_out_tel0,
   output logic [63:0]      rsp_out_tel1,
   output logic             rsp_last
);

   import derq_pkg::*;

   derq_cmd_type  cmd;
   derq_stat_type stat;

   // controller: decides when a beat is taken and steps dumps
   derq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: ring pointers, record storage and the result register
   derq_dpath #(
      .DEPTH      (DEPTH),
      .NAME_BYTES (NAME_BYTES),
      .TEL_BYTES  (TEL_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_name_part0 (req_name_part0),
      .req_name_part1 (req_name_part1),
      .req_name_part2 (req_name_part2),
      .req_tel_part0  (req_tel_part0),
      .req_tel_part1  (req_tel_part1),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_name0  (rsp_out_name0),
      .rsp_out_name1  (rsp_out_name1),
      .rsp_out_name2  (rsp_out_name2),
      .rsp_out_tel0   (rsp_out_tel0),
      .rsp_out_tel1   (rsp_out_tel1),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/derq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module derq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/derq_ctrl.sv =====
// Controller of the record queue: accepts operations, sequences dumps.
// Depends on derq_pkg.
`default_nettype none

module derq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [2:0]             req_kind,
   output logic                        req_ready,
   input  wire derq_pkg::derq_stat_type stat,
   output derq_pkg::derq_cmd_type      cmd
);

   import derq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_kind == KIND_DUMP && !stat.is_empty) begin
                  cmd.dump_start = 1'b1;
                  state_in       = ST_DUMP;
               end else begin
                  cmd.op_go = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            // advance one record whenever the result register frees up
            if (stat.out_free) begin
               cmd.dump_step = 1'b1;
               if (stat.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/derq_dpath.sv =====
// Datapath of the record queue: ring pointers, record RAM, result register.
// Depends on derq_pkg, derq_ram and the assertion macro header.
`default_nettype none

`include "double_ended_record_queue_unit_defines.svh"

module derq_dpath #(
   parameter int DEPTH      = 32,
   parameter int NAME_BYTES = 20,
   parameter int TEL_BYTES  = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire derq_pkg::derq_cmd_type  cmd,
   output derq_pkg::derq_stat_type      stat,
   input  wire logic [2:0]              req_kind,
   input  wire logic [63:0]             req_name_part0,
   input  wire logic [63:0]             req_name_part1,
   input  wire logic [31:0]             req_name_part2,
   input  wire logic [63:0]             req_tel_part0,
   input  wire logic [63:0]             req_tel_part1,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [63:0]                  rsp_out_name0,
   output logic [63:0]                  rsp_out_name1,
   output logic [31:0]                  rsp_out_name2,
   output logic [63:0]                  rsp_out_tel0,
   output logic [63:0]                  rsp_out_tel1,
   output logic                         rsp_last
);

   import derq_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int NAME_W = NAME_BYTES * 8;
   localparam int TEL_W  = TEL_BYTES * 8;
   localparam int REC_W  = NAME_W + TEL_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] dump_ptr_ff, dump_ptr_in;
   logic [CNT_W-1:0] dump_left_ff, dump_left_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [NAME_FULL_W-1:0] rsp_name_ff, rsp_name_in;
   logic [TEL_FULL_W-1:0]  rsp_tel_ff, rsp_tel_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic             is_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [REC_W-1:0] wr_data;
   logic [REC_W-1:0] rd_data;
   logic [CNT_W:0]   back_sum;
   logic [IDX_W-1:0] back_slot;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] ptr_inc;
   logic [NAME_FULL_W-1:0] name_req;
   logic [TEL_FULL_W-1:0]  tel_req;

   assign is_full = (count_ff == FULL_CNT);

   // ring arithmetic; front and count stay below DEPTH when a push goes in
   assign back_sum  = (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(count_ff);
   assign back_slot = (back_sum >= (CNT_W + 1)'(DEPTH))
                      ? IDX_W'(back_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(back_sum);
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
   assign ptr_inc   = (dump_ptr_ff == LAST_IDX) ? '0 : dump_ptr_ff + IDX_W'(1);

   // keep only the bytes a record holds
   assign name_req = {req_name_part2, req_name_part1, req_name_part0};
   assign tel_req  = {req_tel_part1, req_tel_part0};
   assign wr_data  = {tel_req[TEL_W-1:0], name_req[NAME_W-1:0]};

   assign rd_en   = cmd.dump_start | cmd.dump_step;
   assign rd_addr = cmd.dump_start ? front_ff : dump_ptr_ff;

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      dump_ptr_in   = dump_ptr_ff;
      dump_left_in  = dump_left_ff;
      wr_en         = 1'b0;
      wr_addr       = back_slot;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_tel_in    = rsp_tel_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.op_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_DONE;
         rsp_name_in   = '0;
         rsp_tel_in    = '0;
         rsp_last_in   = 1'b1;
         unique case (req_kind)
            KIND_PUSH_FRONT: begin
               if (is_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_PUSH_BACK: begin
               if (is_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_POP_FRONT: begin
               if (count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_POP_BACK: begin
               if (count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            KIND_DUMP: begin
               // only reaches here on an empty list
               rsp_status_in = STAT_EMPTY;
            end
            default: begin
               // unused kinds: drop silently
               rsp_valid_in = rsp_valid_ff & ~rsp_ready;
            end
         endcase
      end

      if (cmd.dump_start) begin
         dump_ptr_in  = front_inc;
         dump_left_in = count_ff;
      end

      if (cmd.dump_step) begin
         dump_ptr_in   = ptr_inc;
         dump_left_in  = dump_left_ff - CNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_RECORD;
         rsp_name_in   = NAME_FULL_W'(rd_data[NAME_W-1:0]);
         rsp_tel_in    = TEL_FULL_W'(rd_data[REC_W-1:NAME_W]);
         rsp_last_in   = (dump_left_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dump_ptr_ff   <= dump_ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_tel_ff    <= rsp_tel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   derq_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.is_empty  = (count_ff == '0);
   assign stat.out_free  = ~rsp_valid_ff | rsp_ready;
   assign stat.dump_last = (dump_left_ff == CNT_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_name0 = rsp_name_ff[63:0];
   assign rsp_out_name1 = rsp_name_ff[127:64];
   assign rsp_out_name2 = rsp_name_ff[159:128];
   assign rsp_out_tel0  = rsp_tel_ff[63:0];
   assign rsp_out_tel1  = rsp_tel_ff[127:64];
   assign rsp_last      = rsp_last_ff;

   `DERQ_ASSERT(a_count_bound, clock, reset, (count_ff <= FULL_CNT), "entry count above depth")
   `DERQ_ASSERT(a_no_write_full, clock, reset, (wr_en |-> !is_full), "write into full ring")
   `DERQ_ASSERT(a_step_has_left, clock, reset, (cmd.dump_step |-> (dump_left_ff != '0)), "dump step with no record left")
   `DERQ_ASSERT(a_dump_holds_list, clock, reset, ((cmd.dump_step && !stat.dump_last) |=> $stable(count_ff)), "list changed during dump")

endmodule

`default_nettype wire
